// File: sv/census_transform_3x3_assert.svh
// Assertion macros shared by the census transform RTL.
`ifndef CENSUS_TRANSFORM_3X3_ASSERT_SVH
`define CENSUS_TRANSFORM_3X3_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CEN3_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CEN3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cen3_pkg.sv
// Shared constants and types of the 3x3 census transform.
package cen3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int PIXEL_W     = 8;
   localparam int CODE_W      = 9;
   localparam int COORD_W     = 10;
   localparam int SIZE_W      = 11;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [SIZE_W-1:0] SIZE_MIN     = 11'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               emit;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
   } meta_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
   } rsp_type;

endpackage

// File: sv/cen3_line_ram.sv
// Single-port-write, registered-read line store memory.
module cen3_line_ram #(
   parameter int DEPTH = cen3_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(cen3_pkg::MAX_WIDTH_DEF),
   parameter int W     = cen3_pkg::PIXEL_W
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cen3_window.sv
// Window column registers, window sum stage and census compare.
module cen3_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [cen3_pkg::PIXEL_W-1:0]   pixel,
   input  logic [cen3_pkg::PIXEL_W-1:0]   top,
   input  logic [cen3_pkg::PIXEL_W-1:0]   mid,
   input  cen3_pkg::meta_type             meta,
   output logic                           out_valid,
   output logic [cen3_pkg::CODE_W-1:0]    code,
   output cen3_pkg::meta_type             meta_out
);

   localparam int SUM_W = cen3_pkg::PIXEL_W + 4;
   localparam int NWIN  = 9;
   localparam int NCOL  = 6;

   logic [cen3_pkg::PIXEL_W-1:0] wcol_ff [NCOL];
   logic [cen3_pkg::PIXEL_W-1:0] win [NWIN];
   logic [cen3_pkg::PIXEL_W-1:0] win_b_ff [NWIN];
   logic [SUM_W-1:0]             sum_in;
   logic [SUM_W-1:0]             sum_b_ff;
   logic                         b_valid_ff;
   cen3_pkg::meta_type           meta_b_ff;

   always_comb begin
      win[0] = wcol_ff[0];
      win[1] = wcol_ff[3];
      win[2] = top;
      win[3] = wcol_ff[1];
      win[4] = wcol_ff[4];
      win[5] = mid;
      win[6] = wcol_ff[2];
      win[7] = wcol_ff[5];
      win[8] = pixel;
      sum_in = ((SUM_W'(win[0]) + SUM_W'(win[1])) + (SUM_W'(win[2]) + SUM_W'(win[3])))
             + ((SUM_W'(win[4]) + SUM_W'(win[5])) + (SUM_W'(win[6]) + SUM_W'(win[7])))
             + SUM_W'(win[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         for (int i = 0; i < NCOL; i++) begin
            wcol_ff[i] <= '0;
         end
      end else begin
         b_valid_ff <= in_valid;
         if (in_valid) begin
            wcol_ff[0] <= wcol_ff[3];
            wcol_ff[1] <= wcol_ff[4];
            wcol_ff[2] <= wcol_ff[5];
            wcol_ff[3] <= top;
            wcol_ff[4] <= mid;
            wcol_ff[5] <= pixel;
         end
      end
      if (in_valid) begin
         for (int i = 0; i < NWIN; i++) begin
            win_b_ff[i] <= win[i];
         end
         sum_b_ff  <= sum_in;
         meta_b_ff <= meta;
      end
   end

   always_comb begin
      for (int k = 0; k < NWIN; k++) begin
         code[k] = (SUM_W'({win_b_ff[k], 3'b000}) + SUM_W'(win_b_ff[k])) > sum_b_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign meta_out  = meta_b_ff;

endmodule

// File: sv/cen3_rsp_queue.sv
// Output queue that holds finished codes until the consumer takes them.
module cen3_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cen3_pkg::rsp_type push_data,
   input  logic              pop_ready,
   output logic              pop_valid,
   output cen3_pkg::rsp_type pop_data
);

   cen3_pkg::rsp_type                 entry_ff [cen3_pkg::QUEUE_DEPTH];
   logic [cen3_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [cen3_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [cen3_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [cen3_pkg::QUEUE_CNT_W-1:0]  count_in;
   logic                              pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + cen3_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - cen3_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cen3_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cen3_pkg::QUEUE_PTR_W'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/census_transform_3x3.sv
// Top level of the streaming 3x3 modified census transform.
//
//   port group  direction  payload
//   req_        in         tdata[7:0] pixel
//   rsp_        out        tdata[8:0] code, [18:9] row, [28:19] col; tlast frame_last
//   csr_        in         index 0 image_width, 1 image_height
//
// One pixel per clock while req_tready is high; a code passes input, window and queue registers.
// Line stores are registered-read memories; window sum takes one stage, compare is combinational.
// req_tready drops only when the 4-entry output queue has all its slots claimed.
// Reset is synchronous; line stores are not cleared, border outputs never read them.
// A stalled consumer holds codes in the queue; the pipeline itself never stalls.
module census_transform_3x3 #(
   parameter int MAX_WIDTH  = cen3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cen3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cen3_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cen3_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [8:0] code, [18:9] row, [28:19] col
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [cen3_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cen3_pkg::SIZE_W-1:0]         csr_wdata
);

   `include "census_transform_3x3_assert.svh"

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP = ($clog2(MAX_WIDTH + 1) > cen3_pkg::SIZE_W) ?
                         $clog2(MAX_WIDTH + 1) : cen3_pkg::SIZE_W;
   localparam int HCMP = ($clog2(MAX_HEIGHT + 1) > cen3_pkg::SIZE_W) ?
                         $clog2(MAX_HEIGHT + 1) : cen3_pkg::SIZE_W;
   localparam int PADW = cen3_pkg::RSP_TDATA_W - cen3_pkg::CODE_W - 2 * cen3_pkg::COORD_W;

   logic [cen3_pkg::SIZE_W-1:0]      width_ff;
   logic [cen3_pkg::SIZE_W-1:0]      height_ff;
   logic [CW-1:0]                    col_ff;
   logic [CW-1:0]                    col_in;
   logic [RW-1:0]                    row_ff;
   logic [RW-1:0]                    row_in;
   logic [cen3_pkg::QUEUE_CNT_W-1:0] credit_ff;
   logic [cen3_pkg::QUEUE_CNT_W-1:0] credit_in;

   logic [WCMP-1:0]                  width_ext;
   logic [WCMP-1:0]                  width_eff;
   logic [WCMP-1:0]                  col_next;
   logic [HCMP-1:0]                  height_ext;
   logic [HCMP-1:0]                  height_eff;
   logic [HCMP-1:0]                  row_next;
   logic [RW+cen3_pkg::COORD_W-1:0]  row_wide;
   logic [CW+cen3_pkg::COORD_W-1:0]  col_wide;
   logic                             row_end;
   logic                             frame_end;
   logic                             accept;
   logic                             pop;
   cen3_pkg::meta_type               meta_a_in;

   logic                             a_valid_ff;
   logic [cen3_pkg::PIXEL_W-1:0]     px_a_ff;
   logic [CW-1:0]                    addr_a_ff;
   cen3_pkg::meta_type               meta_a_ff;

   logic [cen3_pkg::PIXEL_W-1:0]     top_rd;
   logic [cen3_pkg::PIXEL_W-1:0]     mid_rd;
   logic                             b_valid;
   logic [cen3_pkg::CODE_W-1:0]      b_code;
   cen3_pkg::meta_type               meta_b;
   cen3_pkg::rsp_type                push_data;
   cen3_pkg::rsp_type                rsp_data;

   // clamp frame size
   always_comb begin
      width_ext  = WCMP'(width_ff);
      height_ext = HCMP'(height_ff);
      if (width_ext < WCMP'(cen3_pkg::SIZE_MIN)) begin
         width_eff = WCMP'(cen3_pkg::SIZE_MIN);
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         width_eff = WCMP'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (height_ext < HCMP'(cen3_pkg::SIZE_MIN)) begin
         height_eff = HCMP'(cen3_pkg::SIZE_MIN);
      end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
         height_eff = HCMP'(MAX_HEIGHT);
      end else begin
         height_eff = height_ext;
      end
   end

   always_comb begin
      col_next  = WCMP'(col_ff) + WCMP'(1);
      row_next  = HCMP'(row_ff) + HCMP'(1);
      row_end   = (col_next >= width_eff);
      frame_end = row_end && (row_next >= height_eff);
      col_in    = row_end ? '0 : col_next[CW-1:0];
      if (frame_end) begin
         row_in = '0;
      end else if (row_end) begin
         row_in = row_next[RW-1:0];
      end else begin
         row_in = row_ff;
      end
      row_wide       = {{cen3_pkg::COORD_W{1'b0}}, row_ff - RW'(1)};
      col_wide       = {{cen3_pkg::COORD_W{1'b0}}, col_ff - CW'(1)};
      meta_a_in.emit = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      meta_a_in.row  = row_wide[cen3_pkg::COORD_W-1:0];
      meta_a_in.col  = col_wide[cen3_pkg::COORD_W-1:0];
      meta_a_in.last = frame_end;
   end

   assign req_tready = (credit_ff < cen3_pkg::QUEUE_CNT_W'(cen3_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      credit_in = credit_ff;
      if (accept && meta_a_in.emit && !pop) begin
         credit_in = credit_ff + cen3_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !(accept && meta_a_in.emit)) begin
         credit_in = credit_ff - cen3_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= cen3_pkg::WIDTH_RESET;
         height_ff  <= cen3_pkg::HEIGHT_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         credit_ff  <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cen3_pkg::REG_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata;
               end
               cen3_pkg::REG_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         credit_ff  <= credit_in;
         a_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
      if (accept) begin
         px_a_ff   <= req_tdata[cen3_pkg::PIXEL_W-1:0];
         addr_a_ff <= col_ff;
         meta_a_ff <= meta_a_in;
      end
   end

   cen3_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .W     (cen3_pkg::PIXEL_W)
   ) u_upper (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (top_rd),
      .wr_en   (a_valid_ff),
      .wr_addr (addr_a_ff),
      .wr_data (mid_rd)
   );

   cen3_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .W     (cen3_pkg::PIXEL_W)
   ) u_middle (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd),
      .wr_en   (a_valid_ff),
      .wr_addr (addr_a_ff),
      .wr_data (px_a_ff)
   );

   cen3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .pixel     (px_a_ff),
      .top       (top_rd),
      .mid       (mid_rd),
      .meta      (meta_a_ff),
      .out_valid (b_valid),
      .code      (b_code),
      .meta_out  (meta_b)
   );

   always_comb begin
      push_data.code = b_code;
      push_data.row  = meta_b.row;
      push_data.col  = meta_b.col;
      push_data.last = meta_b.last;
   end

   cen3_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid && meta_b.emit),
      .push_data (push_data),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (rsp_data)
   );

   assign rsp_tdata = {{PADW{1'b0}}, rsp_data.col, rsp_data.row, rsp_data.code};
   assign rsp_tlast = rsp_data.last;

   `CEN3_ASSERT_NOW(a_distinct_line_addr, clock, reset, accept && a_valid_ff,
      col_ff != addr_a_ff, "line store read overlaps pending write")
   `CEN3_ASSERT_NOW(a_credit_bound, clock, reset, 1'b1,
      credit_ff <= cen3_pkg::QUEUE_CNT_W'(cen3_pkg::QUEUE_DEPTH),
      "credit count above queue depth")
   `CEN3_ASSERT_NOW(a_rsp_has_credit, clock, reset, rsp_tvalid, credit_ff != '0,
      "response without claimed credit")
   `CEN3_ASSERT_NEXT(a_credit_up, clock, reset, accept && meta_a_in.emit && !pop,
      credit_ff == $past(credit_ff) + cen3_pkg::QUEUE_CNT_W'(1),
      "credit not claimed for request")

endmodule

// File: sim/tb_top.sv
// Testbench for census_transform_3x3: pixel-stream driver, code checker and frame-size sweeps.
`timescale 1ns / 1ps

module tb_top;
   import cen3_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 900;
   localparam int WINDOW_TAPS   = 9;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {STYLE_UNIFORM, STYLE_NARROW, STYLE_BINARY, STYLE_FLAT} pixel_style_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [SIZE_W-1:0]      csr_wdata  = '0;

   census_transform_3x3 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [SIZE_W-1:0]  width_reg = WIDTH_RESET;
   logic [SIZE_W-1:0]  height_reg = HEIGHT_RESET;
   logic [PIXEL_W-1:0] upper_row  [MAX_WIDTH_DEF];
   logic [PIXEL_W-1:0] middle_row [MAX_WIDTH_DEF];
   logic [PIXEL_W-1:0] win_col [6];
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;

   // line store entries that hold defined data
   bit                 upper_known  [MAX_WIDTH_DEF];
   bit                 middle_known [MAX_WIDTH_DEF];

   rsp_type            census_expected [$];
   logic [PIXEL_W-1:0] pixel_backlog [$];

   int unsigned pixels_pushed    = 0;
   int unsigned pixels_accepted  = 0;
   int unsigned codes_checked    = 0;
   int unsigned mismatches       = 0;
   int unsigned settings_written = 0;
   int unsigned cycle_count      = 0;

   int unsigned send_gap   = 0;
   int unsigned send_odds  = 0;
   int unsigned stall_left = 0;
   int unsigned stall_odds = 0;
   logic        req_taken  = 1'b0;

   function automatic int unsigned size_limit(input logic [SIZE_W-1:0] v,
                                              input int unsigned maxv);
      if (v < SIZE_MIN) return 32'(SIZE_MIN);
      if (32'(v) > maxv) return maxv;
      return 32'(v);
   endfunction

   // allow a width change only at frame start or when every column it reaches holds defined data
   function automatic bit width_safe(input logic [SIZE_W-1:0] v);
      int unsigned w;
      w = size_limit(v, MAX_WIDTH_DEF);
      if (col_pos == 0 && row_pos == 0) return 1'b1;
      for (int i = 0; i < w; i++) begin
         if (!upper_known[i] || !middle_known[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_census(input logic [PIXEL_W-1:0] px);
      int unsigned        w, h, total;
      logic [PIXEL_W-1:0] top, mid;
      logic [PIXEL_W-1:0] win [WINDOW_TAPS];
      logic               row_end, frame_end;
      rsp_type            exp_code;
      w = size_limit(width_reg, MAX_WIDTH_DEF);
      h = size_limit(height_reg, MAX_HEIGHT_DEF);
      top = upper_row[col_pos];
      mid = middle_row[col_pos];
      row_end = (col_pos + 1 >= w);
      frame_end = row_end && (row_pos + 1 >= h);
      win = '{win_col[0], win_col[3], top,
              win_col[1], win_col[4], mid,
              win_col[2], win_col[5], px};
      if (row_pos >= 2 && col_pos >= 2) begin
         total = 0;
         foreach (win[k]) total += 32'(win[k]);
         exp_code.code = '0;
         foreach (win[k]) begin
            if (32'(win[k]) * WINDOW_TAPS > total) exp_code.code[k] = 1'b1;
         end
         exp_code.row = COORD_W'(row_pos - 1);
         exp_code.col = COORD_W'(col_pos - 1);
         exp_code.last = frame_end;
         census_expected.push_back(exp_code);
      end
      upper_known[col_pos] = middle_known[col_pos];
      middle_known[col_pos] = 1'b1;
      upper_row[col_pos] = mid;
      middle_row[col_pos] = px;
      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = top;
      win_col[4] = mid;
      win_col[5] = px;
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // check codes, then advance the predictor on an accepted request
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      got.code = rsp_tdata[CODE_W-1:0];
      got.row = rsp_tdata[CODE_W +: COORD_W];
      got.col = rsp_tdata[CODE_W+COORD_W +: COORD_W];
      got.last = rsp_tlast;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (census_expected.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("cycle %0d: unexpected code %03h row %0d col %0d last %0b",
                        cycle_count, got.code, got.row, got.col, got.last);
            mismatches++;
         end else begin
            want = census_expected.pop_front();
            codes_checked++;
            if (got.code !== want.code || got.row !== want.row || got.col !== want.col
                || got.last !== want.last
                || rsp_tdata[RSP_TDATA_W-1:CODE_W+2*COORD_W] !== '0) begin
               if (mismatches < REPORT_LIMIT)
                  $display({"cycle %0d: expected code %03h row %0d col %0d last %0b, ",
                            "got code %03h row %0d col %0d last %0b pad %0h"},
                           cycle_count, want.code, want.row, want.col, want.last,
                           got.code, got.row, got.col, got.last,
                           rsp_tdata[RSP_TDATA_W-1:CODE_W+2*COORD_W]);
               mismatches++;
            end
         end
      end
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_census(req_tdata);
         pixels_accepted++;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap == 0 && send_odds != 0 && $urandom_range(1, send_odds) == 1)
            send_gap = $urandom_range(1, 15);
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_backlog.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pixel_backlog.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            stall_left = $urandom_range(1, 15);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL census_transform_3x3");
         $finish;
      end
   end

   task automatic write_size(input logic [CSR_INDEX_W-1:0] idx,
                             input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      settings_written++;
   endtask

   task automatic queue_pixel(input logic [PIXEL_W-1:0] px);
      pixel_backlog.push_back(px);
      pixels_pushed++;
   endtask

   task automatic drain_all();
      while (pixels_accepted != pixels_pushed || census_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel(input pixel_style_type style,
                                                       input logic [PIXEL_W-1:0] base);
      case (style)
         STYLE_NARROW: return base + PIXEL_W'($urandom_range(0, 3));
         STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         STYLE_FLAT:   return ($urandom_range(0, 9) == 0) ? PIXEL_W'($urandom_range(0, 255))
                                                          : base;
         default:      return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_pixels(input int unsigned count, input pixel_style_type style);
      logic [PIXEL_W-1:0] base;
      base = PIXEL_W'($urandom_range(0, 252));
      repeat (count) queue_pixel(random_pixel(style, base));
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return SIZE_W'($urandom_range(3, 10));
      if (r < 72) return SIZE_W'($urandom_range(0, 2));
      if (r < 80) return SIZE_W'($urandom_range(11, 40));
      if (r < 86) return SIZE_W'(MAX_WIDTH_DEF);
      if (r < 92) return SIZE_W'($urandom_range(MAX_WIDTH_DEF + 1, 2047));
      return SIZE_W'($urandom_range(0, 2047));
   endfunction

   function automatic int unsigned pick_odds();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 16;
      endcase
   endfunction

   initial begin
      int unsigned       random_sent;
      int unsigned       frame_size;
      int unsigned       count;
      bit                first_phase;
      logic [SIZE_W-1:0] new_width;
      pixel_style_type   style;
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      foreach (win_col[i]) win_col[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // smallest frame: flat, lone bright centre, one step above the mean
      write_size(REG_IMAGE_WIDTH, 11'd0);
      write_size(REG_IMAGE_HEIGHT, 11'd1);
      repeat (9) queue_pixel(8'hFF);
      for (int i = 0; i < 9; i++) queue_pixel(i == 4 ? 8'hFF : 8'h00);
      for (int i = 0; i < 9; i++) queue_pixel(i == 8 ? 8'd101 : 8'd100);
      drain_all();

      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_PIXELS) begin
         if (first_phase || $urandom_range(0, 1)) begin
            new_width = pick_size();
            if (width_safe(new_width)) write_size(REG_IMAGE_WIDTH, new_width);
         end
         if (first_phase || $urandom_range(0, 1)) write_size(REG_IMAGE_HEIGHT, pick_size());
         first_phase = 1'b0;
         if (random_sent > RANDOM_PIXELS * 4 / 5) begin
            send_odds = 0;
            stall_odds = 0;
         end else begin
            send_odds = pick_odds();
            stall_odds = pick_odds();
         end
         style = pixel_style_type'($urandom_range(0, 3));
         frame_size = size_limit(width_reg, MAX_WIDTH_DEF)
                      * size_limit(height_reg, MAX_HEIGHT_DEF);
         count = $urandom_range(1, (2 * frame_size + 5 < 160) ? 2 * frame_size + 5 : 160);
         run_pixels(count, style);
         random_sent += count;
         drain_all();
      end

      $display("census run: %0d pixels, %0d codes checked, %0d size register writes",
               pixels_accepted, codes_checked, settings_written);
      $display("sizes from clamped 3 up to %0d wide and %0d tall, with resizes mid-frame",
               MAX_WIDTH_DEF, MAX_HEIGHT_DEF);
      if (mismatches == 0) begin
         $display("PASS census_transform_3x3");
      end else begin
         $display("FAIL census_transform_3x3");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/cen3_pkg.sv
sv/cen3_line_ram.sv
sv/cen3_window.sv
sv/cen3_rsp_queue.sv
sv/census_transform_3x3.sv
sim/tb_top.sv
